// File: hdl/rk45_cash_karp_stepper_defines.svh
//------------------------------------------------------------------------------
// rk45_cash_karp_stepper_defines
// assertion macros for the cash-karp stepper
//------------------------------------------------------------------------------
`ifndef RK45_CASH_KARP_STEPPER_DEFINES_SVH
`define RK45_CASH_KARP_STEPPER_DEFINES_SVH

// implication checked on every edge outside reset
`define RK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define RK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rk45_pkg.sv
//------------------------------------------------------------------------------
// rk45_pkg
// shared constants, coefficient tables and types of the rk45 stepper
//------------------------------------------------------------------------------
`default_nettype none

package rk45_pkg;

    localparam int FracBits = 16;
    localparam int CoefBits = 28;

    // result kinds
    localparam logic [1:0] KIND_EVAL   = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_FAILED = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_NUM_DIMS = 2'd0;
    localparam logic [1:0] CFG_REVERSE  = 2'd1;

    // input modes
    localparam logic MODE_START = 1'b0;

    // coefficient magnitudes rounded to Q.28
    localparam longint CoefOne = longint'(1) <<< CoefBits;
    localparam logic signed [31:0] CK_A00 = 32'((CoefOne + 5 / 2) / 5);
    localparam logic signed [31:0] CK_A10 = 32'((3 * CoefOne + 40 / 2) / 40);
    localparam logic signed [31:0] CK_A11 = 32'((9 * CoefOne + 40 / 2) / 40);
    localparam logic signed [31:0] CK_A20 = 32'((3 * CoefOne + 10 / 2) / 10);
    localparam logic signed [31:0] CK_A21 = 32'((9 * CoefOne + 10 / 2) / 10);
    localparam logic signed [31:0] CK_A22 = 32'((6 * CoefOne + 5 / 2) / 5);
    localparam logic signed [31:0] CK_A30 = 32'((11 * CoefOne + 54 / 2) / 54);
    localparam logic signed [31:0] CK_A31 = 32'((5 * CoefOne + 2 / 2) / 2);
    localparam logic signed [31:0] CK_A32 = 32'((70 * CoefOne + 27 / 2) / 27);
    localparam logic signed [31:0] CK_A33 = 32'((35 * CoefOne + 27 / 2) / 27);
    localparam logic signed [31:0] CK_A40 = 32'((1631 * CoefOne + 55296 / 2) / 55296);
    localparam logic signed [31:0] CK_A41 = 32'((175 * CoefOne + 512 / 2) / 512);
    localparam logic signed [31:0] CK_A42 = 32'((575 * CoefOne + 13824 / 2) / 13824);
    localparam logic signed [31:0] CK_A43 = 32'((44275 * CoefOne + 110592 / 2) / 110592);
    localparam logic signed [31:0] CK_A44 = 32'((253 * CoefOne + 4096 / 2) / 4096);
    localparam logic signed [31:0] CK_B50 = 32'((37 * CoefOne + 378 / 2) / 378);
    localparam logic signed [31:0] CK_B52 = 32'((250 * CoefOne + 621 / 2) / 621);
    localparam logic signed [31:0] CK_B53 = 32'((125 * CoefOne + 594 / 2) / 594);
    localparam logic signed [31:0] CK_B55 = 32'((512 * CoefOne + 1771 / 2) / 1771);

    // a[r][j] for r = 0..4 and b5[0..5] at r = 5
    function automatic logic signed [31:0] coef(input logic [2:0] r, input logic [2:0] j);
        logic signed [31:0] c;
        begin
            c = '0;
            unique case ({r, j})
                {3'd0, 3'd0}: c = CK_A00;
                {3'd1, 3'd0}: c = CK_A10;
                {3'd1, 3'd1}: c = CK_A11;
                {3'd2, 3'd0}: c = CK_A20;
                {3'd2, 3'd1}: c = -CK_A21;
                {3'd2, 3'd2}: c = CK_A22;
                {3'd3, 3'd0}: c = -CK_A30;
                {3'd3, 3'd1}: c = CK_A31;
                {3'd3, 3'd2}: c = -CK_A32;
                {3'd3, 3'd3}: c = CK_A33;
                {3'd4, 3'd0}: c = CK_A40;
                {3'd4, 3'd1}: c = CK_A41;
                {3'd4, 3'd2}: c = CK_A42;
                {3'd4, 3'd3}: c = CK_A43;
                {3'd4, 3'd4}: c = CK_A44;
                {3'd5, 3'd0}: c = CK_B50;
                {3'd5, 3'd2}: c = CK_B52;
                {3'd5, 3'd3}: c = CK_B53;
                {3'd5, 3'd5}: c = CK_B55;
                default:      c = '0;
            endcase
            return c;
        end
    endfunction

    // status from the divider to the sequencer
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
    } t_div_status;

endpackage

`default_nettype wire

// File: hdl/rk45_div.sv
//------------------------------------------------------------------------------
// rk45_div
// restoring divider, one quotient bit per cycle: 2^30 / divisor
//------------------------------------------------------------------------------
`default_nettype none

module rk45_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [33:0]          i_divisor,
    output rk45_pkg::t_div_status     o_status
);
    import rk45_pkg::*;

    localparam int NumBits = 2 * FracBits - 1;

    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [34:0] r_rem;
    logic [31:0] r_quot;
    logic [33:0] r_dvs;
    logic [34:0] w_trial;
    logic        w_bit;
    logic [NumBits-1:0] w_num;

    assign w_num   = NumBits'(1) << (NumBits - 1);
    assign w_trial = {r_rem[33:0], w_num[r_cnt]};
    assign w_bit   = w_trial >= {1'b0, r_dvs};

    // one bit per cycle, msb first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(NumBits - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_bit ? w_trial - {1'b0, r_dvs} : w_trial;
            r_quot <= {r_quot[30:0], w_bit};
        end
    end

    assign o_status = '{busy: r_busy, done: r_done, quot: r_quot};

endmodule

`default_nettype wire

// File: hdl/rk45_mac.sv
//------------------------------------------------------------------------------
// rk45_mac
// shared multiplier with registered product; 32x32 signed/unsigned
//------------------------------------------------------------------------------
`default_nettype none

module rk45_mac (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic signed [65:0]      o_prod
);
    import rk45_pkg::*;

    logic signed [65:0] r_prod;

    // one product per cycle, registered
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: hdl/rk45_cash_karp_stepper.sv
//------------------------------------------------------------------------------
// rk45_cash_karp_stepper
// one cash-karp rk45 step of an autonomous ode against an outside evaluator
//------------------------------------------------------------------------------
// Usage: input words carry a start (mode 0: point and step size) or a returned
// derivative (mode 1, with eval_ok). Every start and every derivative accepted
// during a step yields one output word: an evaluation point (kind 0), a
// finished step (kind 1) or a failed step (kind 2). Derivatives while idle
// are dropped without output.
// Each word is processed by one shared multiplier under a sequencer, one
// component and one stage term per multiply. A start or a failed derivative
// is answered in the cycle after it is taken; derivative k(r+1) for r = 0..4
// runs the stage sums and then advances the evaluation point; k6 runs the
// sums, the step-control divider and, when the solution advances, the update.
// The block is not ready while it works or while its output word waits; a
// stalled output holds, and the next word is taken in the cycle after the
// output word is accepted at the earliest.
// Synchronous active-low reset clears the solution, the step size, the stage
// and the registers num_dims = 3, reverse = 0. The user writes configuration
// by index through i_cfg_we only while idle; the block does not enforce it.
//------------------------------------------------------------------------------
`default_nettype none

`include "rk45_cash_karp_stepper_defines.svh"

module rk45_cash_karp_stepper (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [1:0]         i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_mode,
    input  wire logic signed [31:0] i_vec_x,
    input  wire logic signed [31:0] i_vec_y,
    input  wire logic signed [31:0] i_vec_z,
    input  wire logic [31:0]        i_step_size,
    input  wire logic               i_eval_ok,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [1:0]              o_kind,
    output logic signed [31:0]      o_out_x,
    output logic signed [31:0]      o_out_y,
    output logic signed [31:0]      o_out_z,
    output logic [31:0]             o_out_step,
    output logic                    o_step_reduced
);
    import rk45_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SUM  = 8'b0000_0010,
        S_SUMW = 8'b0000_0100,
        S_ADV  = 8'b0000_1000,
        S_ADVW = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_UPD  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic [1:0]  r_num_dims;
    logic        r_reverse;
    logic [2:0]  r_stage;
    logic signed [31:0] r_base [3];
    logic signed [31:0] r_slopes [15];
    logic [31:0] r_dt;
    logic signed [31:0] r_vec [3];
    logic signed [31:0] r_pt [3];
    logic signed [31:0] r_s5 [3];
    logic [1:0]  r_comp;
    logic [2:0]  r_term;
    logic [2:0]  r_row;
    logic signed [63:0] r_acc;
    logic [33:0] r_l1;
    logic        r_upd;
    logic [1:0]  r_kind;
    logic        r_red;

    logic        w_accept;
    logic        w_three;
    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [65:0] w_prod;
    logic signed [31:0] w_k;
    logic signed [31:0] w_adv;
    logic [63:0] w_mag;
    logic [63:0] w_rnd;
    logic        w_div_start;
    t_div_status w_div;
    logic [33:0] w_q4;
    logic [1:0]  w_last_comp;

    assign w_three     = (r_num_dims == 2'd3);
    assign w_last_comp = w_three ? 2'd2 : 2'd1;
    assign o_stall     = (r_state != S_IDLE);
    assign w_accept    = i_valid && !o_stall;

    // current slope term: stored k, or the incoming k for the newest stage
    always_comb begin
        if (r_term == r_row) w_k = r_vec[r_comp];
        else w_k = r_slopes[4'(r_term) * 4'd3 + 4'(r_comp)];
    end

    // shared multiplier operands
    always_comb begin
        if (r_state == S_SUM || r_state == S_SUMW) begin
            w_ma = 33'(coef(r_row, r_term));
            w_mb = 33'(w_k);
        end else begin
            w_ma = r_upd ? 33'(r_s5[r_comp]) : 33'(r_pt[r_comp]);
            w_mb = {1'b0, r_dt};
        end
    end

    rk45_mac u_mac (
        .i_clk  (i_clk),
        .i_a    (w_ma[32] ? -w_ma : w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    // advance: base +/- round(|s| * dt), saturate
    assign w_mag = 64'(w_prod);
    assign w_rnd = (w_mag + (64'd1 << (FracBits - 1))) >> FracBits;
    always_comb begin
        logic signed [65:0] t;
        logic               neg;
        neg = (r_upd ? r_s5[r_comp][31] : r_pt[r_comp][31]) ^ r_reverse;
        t   = neg ? 66'(r_base[r_comp]) - 66'(w_rnd) : 66'(r_base[r_comp]) + 66'(w_rnd);
        if (t > 66'sh7FFF_FFFF) w_adv = 32'sh7FFF_FFFF;
        else if (t < -66'sh8000_0000) w_adv = 32'sh8000_0000;
        else w_adv = 32'(t);
    end

    rk45_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_divisor ((r_l1 == '0) ? 34'd1 : r_l1),
        .o_status  (w_div)
    );

    // start the quotient once the l1 norm is complete
    assign w_div_start = (r_state == S_DIV) && !w_div.busy && !w_div.done;
    assign w_q4        = {w_div.quot, 2'b00};

    // rounding helpers on a full accumulator value
    function automatic logic signed [31:0] w_sum_of(input logic signed [63:0] a);
        logic [63:0] m;
        logic [63:0] rr;
        begin
            m  = a[63] ? 64'(-a) : 64'(a);
            rr = (m + (64'd1 << (CoefBits - 1))) >> CoefBits;
            if (rr > 64'h7FFF_FFFF && !a[63]) return 32'sh7FFF_FFFF;
            if (rr > 64'h8000_0000 && a[63]) return 32'sh8000_0000;
            return a[63] ? -32'(rr) : 32'(rr);
        end
    endfunction

    function automatic logic [31:0] abs_of(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= 2'd3;
            r_reverse  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUM_DIMS: r_num_dims <= i_cfg_data;
                CFG_REVERSE:  r_reverse  <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= '0;
            r_base  <= '{default: '0};
            r_dt    <= '0;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_vec[0] <= i_vec_x;
                        r_vec[1] <= i_vec_y;
                        r_vec[2] <= w_three ? i_vec_z : '0;
                        r_comp   <= '0;
                        r_term   <= '0;
                        r_acc    <= '0;
                        r_l1     <= '0;
                        r_upd    <= 1'b0;
                        r_red    <= 1'b0;
                        if (i_mode == MODE_START) begin
                            r_base[0] <= i_vec_x;
                            r_base[1] <= i_vec_y;
                            r_base[2] <= w_three ? i_vec_z : '0;
                            r_dt      <= i_step_size;
                            r_stage   <= 3'd1;
                            r_kind    <= KIND_EVAL;
                            r_pt[0]   <= i_vec_x;
                            r_pt[1]   <= i_vec_y;
                            r_pt[2]   <= w_three ? i_vec_z : '0;
                            o_valid   <= 1'b1;
                            r_state   <= S_OUT;
                        end else if (r_stage != '0) begin
                            if (!i_eval_ok) begin
                                r_stage <= '0;
                                r_kind  <= KIND_FAILED;
                                r_pt    <= r_base;
                                o_valid <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_row   <= r_stage - 3'd1;
                                r_state <= S_SUM;
                            end
                        end
                    end
                end
                // issue one coefficient * k product
                S_SUM: r_state <= S_SUMW;
                S_SUMW: begin
                    logic signed [63:0] p;
                    p = w_ma[32] ? -64'(w_prod) : 64'(w_prod);
                    if (r_term == r_row) begin
                        if (r_row == 3'd5) begin
                            r_s5[r_comp] <= (r_comp > w_last_comp) ? '0 : w_sum_of(r_acc + p);
                            r_l1 <= r_l1 + ((r_comp > w_last_comp) ? 34'd0
                                                : 34'(abs_of(w_sum_of(r_acc + p))));
                        end else begin
                            r_pt[r_comp] <= w_sum_of(r_acc + p);
                            if (r_comp == 2'd0)
                                for (int i = 0; i < 3; i++)
                                    r_slopes[4'(r_row) * 4'd3 + 4'(i)] <= r_vec[i];
                        end
                        r_acc  <= '0;
                        r_term <= '0;
                        if (r_comp == 2'd2) begin
                            r_comp  <= '0;
                            r_state <= (r_row == 3'd5) ? S_DIV : S_ADV;
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_state <= S_SUM;
                        end
                    end else begin
                        r_acc   <= r_acc + p;
                        r_term  <= r_term + 3'd1;
                        r_state <= S_SUM;
                    end
                end
                // wait for the step-control quotient
                S_DIV: begin
                    if (w_div.done) begin
                        r_stage <= '0;
                        r_kind  <= KIND_DONE;
                        if (w_q4 < {2'b00, r_dt}) begin
                            r_dt    <= w_div.quot;
                            r_red   <= 1'b1;
                            r_pt    <= r_base;
                            o_valid <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_upd   <= 1'b1;
                            r_state <= S_ADV;
                        end
                    end
                end
                // issue one |s| * dt product
                S_ADV: r_state <= S_ADVW;
                S_ADVW: begin
                    logic signed [31:0] v;
                    v = (r_comp > w_last_comp) ? '0 : w_adv;
                    if (r_upd) r_base[r_comp] <= v;
                    r_pt[r_comp] <= v;
                    if (r_comp == 2'd2) begin
                        r_comp <= '0;
                        if (!r_upd) begin
                            r_stage <= r_stage + 3'd1;
                            r_kind  <= KIND_EVAL;
                        end
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_comp  <= r_comp + 2'd1;
                        r_state <= S_ADV;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_kind         = r_kind;
    assign o_out_x        = r_pt[0];
    assign o_out_y        = r_pt[1];
    assign o_out_z        = r_pt[2];
    assign o_out_step     = r_dt;
    assign o_step_reduced = r_red;

    // handshake and sequencing checks
    `RK_ASSERT_IMP(a_busy_no_accept, i_clk, i_rst_n, r_state != S_IDLE, o_stall,
        "input accepted while busy")
    `RK_ASSERT_IMP(a_valid_in_out, i_clk, i_rst_n, o_valid, r_state == S_OUT,
        "output valid outside output state")
    `RK_ASSERT_NEXT(a_div_runs, i_clk, i_rst_n, w_div_start, w_div.busy,
        "divider did not start")
    `RK_ASSERT_IMP(a_div_stage, i_clk, i_rst_n, r_state == S_DIV,
        r_stage == 3'd6, "division outside final stage")

endmodule

`default_nettype wire
